/* sv/spherical_boundary_restraint_force_core_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef SPHERICAL_BOUNDARY_RESTRAINT_FORCE_CORE_ASSERT_SVH
`define SPHERICAL_BOUNDARY_RESTRAINT_FORCE_CORE_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define SBRF_ASSERT_SAME(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sbrf same-cycle check failed");

// Condition holds in the cycle after the trigger.
`define SBRF_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sbrf next-cycle check failed");

`endif

/* sv/sbrf_pkg.sv */
`timescale 1ns / 1ps
package sbrf_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int MAX_EXPONENT_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_K  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 3'd5;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               last_item;
    } in_req_t;

    typedef struct packed {
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic               outside;
        logic signed [47:0] energy_sum;
        logic               last_out;
    } out_req_t;

    typedef enum logic [3:0] {
        OP_SQ,
        OP_R2,
        OP_SQRT,
        OP_POW,
        OP_EPOW,
        OP_GAIN,
        OP_GAINJ,
        OP_FMUL,
        OP_DIV,
        OP_ETERM,
        OP_FINISH
    } op_t;

    typedef struct packed {
        logic       load;
        logic       start;
        op_t        op;
        logic [1:0] axis;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic outside;
        logic pow_more;
    } dp_status_t;

endpackage

/* sv/spherical_boundary_restraint_force_core.sv */
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// config    cfg_we                  cfg_index, cfg_data
// request   in_valid / in_stall     in_data  (sbrf_pkg::in_req_t)
// result    out_valid / out_stall   out_data (sbrf_pkg::out_req_t)
//
// One request is worked on at a time; in_stall is high until its result is taken.
// A particle inside the sphere takes four multiplies and then finishes.
// One outside goes on through the shared multiply, the 34-step square root and three
// 48-step divisions, with more power multiplies the larger j, the exponent in effect.
// Reset is asynchronous and active low; configuration returns to its reset values.
module spherical_boundary_restraint_force_core #(
    parameter int FRAC_BITS    = sbrf_pkg::FRAC_BITS_DEF,
    parameter int MAX_EXPONENT = sbrf_pkg::MAX_EXPONENT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sbrf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sbrf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  sbrf_pkg::in_req_t                in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output sbrf_pkg::out_req_t               out_data
);

    sbrf_pkg::dp_cmd_t    cmd;
    sbrf_pkg::dp_status_t status;

    sbrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    sbrf_dp #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

/* sv/sbrf_mul.sv */
`timescale 1ns / 1ps
module sbrf_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [63:0]   x,
    input  logic [63:0]   y,
    output logic          done,
    output logic [127:0]  prod
);

    logic [63:0]  x_reg;
    logic [63:0]  y_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [127:0] acc_reg;
    logic [127:0] acc_next;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [31:0]  xs;
    logic [31:0]  ys;
    logic [1:0]   sh_next;
    logic [127:0] pp_ext;

    always_comb
    begin
        xs      = cnt_reg[1] ? x_reg[63:32] : x_reg[31:0];
        ys      = cnt_reg[0] ? y_reg[63:32] : y_reg[31:0];
        sh_next = 2'({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]});
        pp_ext  = {64'd0, pp_reg};
        case (sh_reg)
            2'd0:    acc_next = acc_reg + pp_ext;
            2'd1:    acc_next = acc_reg + (pp_ext << 32);
            2'd2:    acc_next = acc_reg + (pp_ext << 64);
            default: acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            y_reg   <= y;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                pp_reg <= xs * ys;
                sh_reg <= sh_next;
            end
            if (cnt_reg != 3'd0)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

/* sv/sbrf_dp.sv */
`timescale 1ns / 1ps
module sbrf_dp #(
    parameter int FRAC_BITS    = sbrf_pkg::FRAC_BITS_DEF,
    parameter int MAX_EXPONENT = sbrf_pkg::MAX_EXPONENT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sbrf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sbrf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  sbrf_pkg::in_req_t                in_data,
    input  sbrf_pkg::dp_cmd_t                cmd,
    output sbrf_pkg::dp_status_t             status,
    output sbrf_pkg::out_req_t               out_data
);

    localparam int JW = $clog2(MAX_EXPONENT + 1);
    localparam logic signed [64:0] OUT_MAX65 = 65'sd140737488355327;
    localparam logic signed [64:0] OUT_MIN65 = -65'sd140737488355328;

    function automatic logic [61:0] sat62(input logic [127:0] v);
        logic [61:0] res;
        if (v[127:62] != '0)
            res = '1;
        else
            res = v[61:0];
        return res;
    endfunction

    logic signed [31:0] cx_reg, cy_reg, cz_reg, k_reg;
    logic [30:0]        radius_reg;
    logic [4:0]         exp_reg;

    logic [32:0]        m_reg [0:2];
    logic [2:0]         rcneg_reg;
    logic               last_reg;
    logic [65:0]        s_reg;
    logic               outside_reg;
    sbrf_pkg::op_t      op_reg;
    logic [1:0]         axis_reg;
    logic               run_reg;
    logic               done_reg;
    logic [5:0]         cnt_reg;
    logic [33:0]        sroot_reg;
    logic [34:0]        srem_reg;
    logic [67:0]        ssh_reg;
    logic [32:0]        r_reg;
    logic [32:0]        a_reg;
    logic [61:0]        p_reg, e_reg, g_reg, et_reg;
    logic [95:0]        n_reg;
    logic [32:0]        drem_reg;
    logic [47:0]        dq_reg;
    logic               dsat_reg;
    logic [JW-1:0]      pow_cnt_reg;
    logic signed [47:0] force_reg [0:2];
    logic signed [47:0] acc_reg;
    sbrf_pkg::out_req_t out_reg;

    logic [JW-1:0]      j_eff;
    logic [31:0]        kmag;
    logic [63:0]        mul_x, mul_y;
    logic               mul_start, mul_done;
    logic [127:0]       prod;

    logic [36:0]        s_t, s_trial;
    logic               s_ge;
    logic [34:0]        srem_next;
    logic [33:0]        sroot_next;
    logic [32:0]        a_next;

    logic [33:0]        d_t;
    logic               d_ge;
    logic [32:0]        drem_next;
    logic [47:0]        dq_next;
    logic [47:0]        fmag;
    logic signed [47:0] force_next;

    logic signed [63:0] et_s;
    logic signed [64:0] acc_sum;
    logic signed [47:0] acc_sat;
    logic signed [47:0] energy_next;

    logic signed [32:0] rc [0:2];

    always_comb
    begin
        if (exp_reg < 5'd2)
            j_eff = JW'(2);
        else if (32'(exp_reg) > MAX_EXPONENT)
            j_eff = JW'(MAX_EXPONENT);
        else
            j_eff = JW'(exp_reg);
        kmag = k_reg[31] ? (~k_reg + 32'd1) : k_reg;
    end

    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        case (cmd.op)
            sbrf_pkg::OP_SQ:
            begin
                mul_x = 64'(m_reg[cmd.axis]);
                mul_y = 64'(m_reg[cmd.axis]);
            end
            sbrf_pkg::OP_R2:
            begin
                mul_x = 64'(radius_reg);
                mul_y = 64'(radius_reg);
            end
            sbrf_pkg::OP_POW, sbrf_pkg::OP_EPOW:
            begin
                mul_x = 64'(p_reg);
                mul_y = 64'(a_reg);
            end
            sbrf_pkg::OP_GAIN:
            begin
                mul_x = 64'(kmag);
                mul_y = 64'(p_reg);
            end
            sbrf_pkg::OP_GAINJ:
            begin
                mul_x = 64'(g_reg);
                mul_y = 64'(j_eff);
            end
            sbrf_pkg::OP_FMUL:
            begin
                mul_x = 64'(m_reg[cmd.axis]);
                mul_y = 64'(g_reg);
            end
            sbrf_pkg::OP_ETERM:
            begin
                mul_x = 64'(kmag);
                mul_y = 64'(e_reg);
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
        mul_start = cmd.start && (cmd.op inside {sbrf_pkg::OP_SQ, sbrf_pkg::OP_R2,
            sbrf_pkg::OP_POW, sbrf_pkg::OP_EPOW, sbrf_pkg::OP_GAIN, sbrf_pkg::OP_GAINJ,
            sbrf_pkg::OP_FMUL, sbrf_pkg::OP_ETERM});
    end

    sbrf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .prod  (prod)
    );

    always_comb
    begin
        s_t        = {srem_reg, ssh_reg[67:66]};
        s_trial    = {1'b0, sroot_reg, 2'b01};
        s_ge       = s_t >= s_trial;
        srem_next  = s_ge ? 35'(s_t - s_trial) : s_t[34:0];
        sroot_next = {sroot_reg[32:0], s_ge};
        a_next     = sroot_next[32:0] - {2'b00, radius_reg};

        d_t        = {drem_reg, dq_reg[47]};
        d_ge       = d_t >= {1'b0, r_reg};
        drem_next  = d_ge ? 33'(d_t - {1'b0, r_reg}) : d_t[32:0];
        dq_next    = {dq_reg[46:0], d_ge};
        if (dsat_reg || dq_next[47])
            fmag = {1'b0, {47{1'b1}}};
        else
            fmag = {1'b0, dq_next[46:0]};
        if (rcneg_reg[axis_reg] != k_reg[31])
            force_next = $signed(fmag);
        else
            force_next = -$signed(fmag);

        et_s    = k_reg[31] ? -$signed({2'b00, et_reg}) : $signed({2'b00, et_reg});
        acc_sum = 65'(acc_reg) + 65'(et_s);
        if (acc_sum > OUT_MAX65)
            acc_sat = OUT_MAX65[47:0];
        else if (acc_sum < OUT_MIN65)
            acc_sat = OUT_MIN65[47:0];
        else
            acc_sat = acc_sum[47:0];
        energy_next = outside_reg ? acc_sat : acc_reg;

        rc[0] = $signed({in_data.pos_x[31], in_data.pos_x}) - $signed({cx_reg[31], cx_reg});
        rc[1] = $signed({in_data.pos_y[31], in_data.pos_y}) - $signed({cy_reg[31], cy_reg});
        rc[2] = $signed({in_data.pos_z[31], in_data.pos_z}) - $signed({cz_reg[31], cz_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg      <= '0;
            cy_reg      <= '0;
            cz_reg      <= '0;
            radius_reg  <= '0;
            k_reg       <= 32'sd65536;
            exp_reg     <= 5'd2;
            acc_reg     <= '0;
            run_reg     <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            pow_cnt_reg <= JW'(2);
            op_reg      <= sbrf_pkg::OP_SQ;
            axis_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    sbrf_pkg::CFG_CENTER_X: cx_reg     <= cfg_data;
                    sbrf_pkg::CFG_CENTER_Y: cy_reg     <= cfg_data;
                    sbrf_pkg::CFG_CENTER_Z: cz_reg     <= cfg_data;
                    sbrf_pkg::CFG_RADIUS:   radius_reg <= cfg_data[30:0];
                    sbrf_pkg::CFG_FORCE_K:  k_reg      <= cfg_data;
                    sbrf_pkg::CFG_EXPONENT: exp_reg    <= cfg_data[4:0];
                    default:                ;
                endcase
            end
            if (cmd.load)
            begin
                pow_cnt_reg <= JW'(2);
            end
            if (cmd.start)
            begin
                op_reg   <= cmd.op;
                axis_reg <= cmd.axis;
                if (cmd.op == sbrf_pkg::OP_SQRT)
                begin
                    cnt_reg <= 6'd34;
                    run_reg <= 1'b1;
                end
                else if (cmd.op == sbrf_pkg::OP_DIV)
                begin
                    cnt_reg <= 6'd48;
                    run_reg <= 1'b1;
                end
                else if (cmd.op == sbrf_pkg::OP_FINISH)
                begin
                    done_reg <= 1'b1;
                    acc_reg  <= last_reg ? 48'sd0 : energy_next;
                end
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            if (mul_done && op_reg == sbrf_pkg::OP_POW)
            begin
                pow_cnt_reg <= pow_cnt_reg + JW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rcneg_reg[i] <= rc[i][32];
                m_reg[i]     <= rc[i][32] ? 33'(-rc[i]) : 33'(rc[i]);
                force_reg[i] <= '0;
            end
            last_reg <= in_data.last_item;
            s_reg    <= '0;
        end
        if (cmd.start)
        begin
            if (cmd.op == sbrf_pkg::OP_SQRT)
            begin
                ssh_reg   <= {2'b00, s_reg};
                sroot_reg <= '0;
                srem_reg  <= '0;
            end
            else if (cmd.op == sbrf_pkg::OP_DIV)
            begin
                dsat_reg <= n_reg >= {15'd0, r_reg, 48'd0};
                drem_reg <= n_reg[80:48];
                dq_reg   <= n_reg[47:0];
            end
            else if (cmd.op == sbrf_pkg::OP_FINISH)
            begin
                out_reg.force_x    <= force_reg[0];
                out_reg.force_y    <= force_reg[1];
                out_reg.force_z    <= force_reg[2];
                out_reg.outside    <= outside_reg;
                out_reg.energy_sum <= last_reg ? energy_next : 48'sd0;
                out_reg.last_out   <= last_reg;
            end
        end
        else if (run_reg)
        begin
            if (op_reg == sbrf_pkg::OP_SQRT)
            begin
                ssh_reg   <= {ssh_reg[65:0], 2'b00};
                sroot_reg <= sroot_next;
                srem_reg  <= srem_next;
                if (cnt_reg == 6'd1)
                begin
                    r_reg <= sroot_next[32:0];
                    a_reg <= a_next;
                    p_reg <= 62'(a_next);
                end
            end
            else
            begin
                drem_reg <= drem_next;
                dq_reg   <= dq_next;
                if (cnt_reg == 6'd1)
                begin
                    force_reg[axis_reg] <= force_next;
                end
            end
        end
        if (mul_done)
        begin
            case (op_reg)
                sbrf_pkg::OP_SQ:    s_reg       <= s_reg + prod[65:0];
                sbrf_pkg::OP_R2:    outside_reg <= s_reg > prod[65:0];
                sbrf_pkg::OP_POW:   p_reg       <= sat62(prod >> FRAC_BITS);
                sbrf_pkg::OP_EPOW:  e_reg       <= sat62(prod >> FRAC_BITS);
                sbrf_pkg::OP_GAIN:  g_reg       <= sat62(prod >> FRAC_BITS);
                sbrf_pkg::OP_GAINJ: g_reg       <= sat62(prod);
                sbrf_pkg::OP_FMUL:  n_reg       <= prod[95:0];
                sbrf_pkg::OP_ETERM: et_reg      <= sat62(prod >> FRAC_BITS);
                default:            ;
            endcase
        end
    end

    assign status.done     = mul_done | done_reg;
    assign status.outside  = outside_reg;
    assign status.pow_more = pow_cnt_reg < j_eff;
    assign out_data        = out_reg;

endmodule

/* sv/sbrf_ctrl.sv */
`timescale 1ns / 1ps
module sbrf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  sbrf_pkg::dp_status_t status,
    output sbrf_pkg::dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_OUT
    } state_t;

    state_t        state_reg;
    sbrf_pkg::op_t op_reg;
    logic [1:0]    axis_reg;
    logic          skip;

    always_comb
    begin
        skip = (op_reg == sbrf_pkg::OP_SQRT && !status.outside) ||
               (op_reg == sbrf_pkg::OP_POW && !status.pow_more);
        cmd.load  = in_valid && state_reg == S_IDLE;
        cmd.start = state_reg == S_ISSUE && !skip;
        cmd.op    = op_reg;
        cmd.axis  = axis_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= sbrf_pkg::OP_SQ;
            axis_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_ISSUE;
                        op_reg    <= sbrf_pkg::OP_SQ;
                        axis_reg  <= '0;
                    end
                end
                S_ISSUE:
                begin
                    if (skip)
                        op_reg <= (op_reg == sbrf_pkg::OP_SQRT) ? sbrf_pkg::OP_FINISH
                                                                : sbrf_pkg::OP_EPOW;
                    else
                        state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (status.done)
                    begin
                        state_reg <= S_ISSUE;
                        case (op_reg)
                            sbrf_pkg::OP_SQ:
                            begin
                                if (axis_reg == 2'd2)
                                begin
                                    op_reg   <= sbrf_pkg::OP_R2;
                                    axis_reg <= '0;
                                end
                                else
                                    axis_reg <= axis_reg + 2'd1;
                            end
                            sbrf_pkg::OP_R2:    op_reg <= sbrf_pkg::OP_SQRT;
                            sbrf_pkg::OP_SQRT:  op_reg <= sbrf_pkg::OP_POW;
                            sbrf_pkg::OP_POW:   op_reg <= sbrf_pkg::OP_POW;
                            sbrf_pkg::OP_EPOW:  op_reg <= sbrf_pkg::OP_GAIN;
                            sbrf_pkg::OP_GAIN:  op_reg <= sbrf_pkg::OP_GAINJ;
                            sbrf_pkg::OP_GAINJ:
                            begin
                                op_reg   <= sbrf_pkg::OP_FMUL;
                                axis_reg <= '0;
                            end
                            sbrf_pkg::OP_FMUL:  op_reg <= sbrf_pkg::OP_DIV;
                            sbrf_pkg::OP_DIV:
                            begin
                                if (axis_reg == 2'd2)
                                    op_reg <= sbrf_pkg::OP_ETERM;
                                else
                                begin
                                    op_reg   <= sbrf_pkg::OP_FMUL;
                                    axis_reg <= axis_reg + 2'd1;
                                end
                            end
                            sbrf_pkg::OP_ETERM: op_reg <= sbrf_pkg::OP_FINISH;
                            sbrf_pkg::OP_FINISH: state_reg <= S_OUT;
                            default:            state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = state_reg == S_OUT;

endmodule

/* sv/sbrf_checker.sv */
`timescale 1ns / 1ps
`include "spherical_boundary_restraint_force_core_assert.svh"
module sbrf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input sbrf_pkg::out_req_t               out_data
);

    `SBRF_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall && !out_valid)
    `SBRF_ASSERT_SAME(a_result_blocks, clk, rst_n, out_valid, in_stall)
    `SBRF_ASSERT_SAME(a_inside_zero, clk, rst_n, out_valid && !out_data.outside, out_data.force_x == '0 && out_data.force_y == '0 && out_data.force_z == '0)
    `SBRF_ASSERT_SAME(a_energy_gate, clk, rst_n, out_valid && !out_data.last_out, out_data.energy_sum == '0)
    `SBRF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind spherical_boundary_restraint_force_core sbrf_checker u_sbrf_checker (.*);

/* bench/spherical_boundary_restraint_force_core_tb.sv */
`timescale 1ns / 1ps
module spherical_boundary_restraint_force_core_tb;

    localparam logic [127:0] MAG_CAP = (128'd1 << 62) - 1;
    localparam longint OUT_HI = (64'sd1 <<< 47) - 1;
    localparam longint OUT_LO = -(64'sd1 <<< 47);
    localparam int CYCLE_LIMIT = 4000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [sbrf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sbrf_pkg::CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    sbrf_pkg::in_req_t in_data;
    logic out_valid;
    logic out_stall;
    sbrf_pkg::out_req_t out_data;

    spherical_boundary_restraint_force_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    longint ctr_x, ctr_y, ctr_z;
    longint radius_q;
    longint gain_k;
    int pow_j;
    longint energy_acc;

    sbrf_pkg::in_req_t particle_q[$];
    sbrf_pkg::out_req_t expected_q[$];
    int errors;
    int send_gap;
    int stall_left;
    bit no_idle;
    int cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [127:0] scaled_mul(logic [127:0] x, logic [127:0] y, int sh);
        logic [127:0] p;
        p = (x * y) >> sh;
        return (p > MAG_CAP) ? MAG_CAP : p;
    endfunction

    function automatic sbrf_pkg::out_req_t predict_force(sbrf_pkg::in_req_t item);
        sbrf_pkg::out_req_t res;
        longint rc[3];
        logic [127:0] mag[3];
        logic [127:0] sq_sum, rad_sq, root, cand, excess, pw, en, gn, kmag, quo;
        longint fv, term;
        int jj;
        bit neg;
        rc[0] = longint'(item.pos_x) - ctr_x;
        rc[1] = longint'(item.pos_y) - ctr_y;
        rc[2] = longint'(item.pos_z) - ctr_z;
        res = '0;
        sq_sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (rc[i] < 0) ? 128'(-rc[i]) : 128'(rc[i]);
            sq_sum = sq_sum + mag[i] * mag[i];
        end
        rad_sq = 128'(radius_q) * 128'(radius_q);
        if (sq_sum > rad_sq)
        begin
            root = 0;
            for (int b = 34; b >= 0; b--)
            begin
                cand = root | (128'd1 << b);
                if (cand * cand <= sq_sum)
                    root = cand;
            end
            excess = root - 128'(radius_q);
            jj = (pow_j < 2) ? 2 : ((pow_j > 16) ? 16 : pow_j);
            kmag = (gain_k < 0) ? 128'(-gain_k) : 128'(gain_k);
            pw = excess;
            for (int n = 2; n < jj; n++)
                pw = scaled_mul(pw, excess, 16);
            en = scaled_mul(pw, excess, 16);
            gn = scaled_mul(kmag, pw, 16);
            gn = scaled_mul(gn, 128'(jj), 0);
            res.outside = 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                quo = (mag[i] * gn) / root;
                fv = (quo > 128'(OUT_HI)) ? OUT_HI : longint'(quo);
                neg = (rc[i] < 0) != (gain_k < 0);
                if (!neg)
                    fv = -fv;
                if (rc[i] == 0 || gain_k == 0)
                    fv = 0;
                case (i)
                    0: res.force_x = fv[47:0];
                    1: res.force_y = fv[47:0];
                    default: res.force_z = fv[47:0];
                endcase
            end
            term = longint'(scaled_mul(kmag, en, 16));
            if (gain_k < 0)
                term = -term;
            energy_acc = energy_acc + term;
            if (energy_acc > OUT_HI)
                energy_acc = OUT_HI;
            if (energy_acc < OUT_LO)
                energy_acc = OUT_LO;
        end
        res.last_out = item.last_item;
        if (item.last_item)
        begin
            res.energy_sum = energy_acc[47:0];
            energy_acc = 0;
        end
        return res;
    endfunction

    task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && in_stall))
        begin
            if (in_valid)
                expected_q = {expected_q, predict_force(in_data)};
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (particle_q.size() > 0)
            begin
                in_data <= particle_q.pop_front();
                in_valid <= 1'b1;
                send_gap <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        sbrf_pkg::out_req_t exp_r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    check_field("force_x", exp_r.force_x, out_data.force_x);
                    check_field("force_y", exp_r.force_y, out_data.force_y);
                    check_field("force_z", exp_r.force_z, out_data.force_z);
                    check_field("outside", 48'(exp_r.outside), 48'(out_data.outside));
                    check_field("energy_sum", exp_r.energy_sum, out_data.energy_sum);
                    check_field("last_out", 48'(exp_r.last_out), 48'(out_data.last_out));
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
            end
        end
    end

    task automatic write_reg(logic [sbrf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            sbrf_pkg::CFG_CENTER_X: ctr_x = longint'($signed(val));
            sbrf_pkg::CFG_CENTER_Y: ctr_y = longint'($signed(val));
            sbrf_pkg::CFG_CENTER_Z: ctr_z = longint'($signed(val));
            sbrf_pkg::CFG_RADIUS:   radius_q = longint'(val[30:0]);
            sbrf_pkg::CFG_FORCE_K:  gain_k = longint'($signed(val));
            sbrf_pkg::CFG_EXPONENT: pow_j = int'(val[4:0]);
            default: ;
        endcase
    endtask

    task automatic setup_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                logic [31:0] rad, logic [31:0] k, logic [31:0] j);
        write_reg(sbrf_pkg::CFG_CENTER_X, cx);
        write_reg(sbrf_pkg::CFG_CENTER_Y, cy);
        write_reg(sbrf_pkg::CFG_CENTER_Z, cz);
        write_reg(sbrf_pkg::CFG_RADIUS, rad);
        write_reg(sbrf_pkg::CFG_FORCE_K, k);
        write_reg(sbrf_pkg::CFG_EXPONENT, j);
    endtask

    task automatic add_particle(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
        sbrf_pkg::in_req_t item;
        item.pos_x = x;
        item.pos_y = y;
        item.pos_z = z;
        item.last_item = last;
        particle_q = {particle_q, item};
    endtask

    task automatic wait_drained();
        while (particle_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [31:0] near_axis(longint ctr, longint span);
        longint unsigned rnd;
        longint off;
        rnd = {$urandom, $urandom};
        off = longint'(rnd % longint'(2 * span + 1)) - span;
        return 32'(ctr + off);
    endfunction

    task automatic random_phase(int count);
        logic [31:0] rad, k;
        longint span;
        int sel;
        sel = $urandom_range(0, 3);
        rad = (sel == 0) ? $urandom_range(0, 32'h0004_0000) :
              (sel == 1) ? $urandom_range(0, 32'h0100_0000) :
              (sel == 2) ? $urandom_range(0, 32'h0000_4000) : ($urandom >> 1);
        sel = $urandom_range(0, 5);
        k = (sel == 0) ? $urandom : (sel == 1) ? 32'd0 :
            (sel == 2) ? -($urandom_range(1, 4) << 16) : $urandom_range(1, 32'h0004_0000);
        no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1))
            setup_sphere($urandom, $urandom, $urandom, rad, k, $urandom_range(0, 31));
        else
            setup_sphere($urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                         $urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                         $urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                         rad, k, 2 * $urandom_range(1, 8));
        span = radius_q + radius_q / 2 + 64;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 4) == 0)
                add_particle($urandom, $urandom, $urandom, $urandom_range(0, 7) == 0);
            else
                add_particle(near_axis(ctr_x, span), near_axis(ctr_y, span),
                             near_axis(ctr_z, span), $urandom_range(0, 7) == 0);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        errors = 0;
        send_gap = 0;
        stall_left = 0;
        no_idle = 1'b0;
        cycles = 0;
        ctr_x = 0;
        ctr_y = 0;
        ctr_z = 0;
        radius_q = 0;
        gain_k = 65536;
        pow_j = 2;
        energy_acc = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        add_particle(32'h0, 32'h0, 32'h0, 1'b0);
        add_particle(32'h1, 32'h0, 32'h0, 1'b0);
        add_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        add_particle(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        add_particle(32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b1);
        wait_drained();

        setup_sphere(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'd0);
        add_particle(32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b0);
        add_particle(32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b0);
        add_particle(32'h0, 32'h0, 32'hffff_ffff, 1'b1);
        wait_drained();

        setup_sphere(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'hffff_0000, 32'd3);
        add_particle(32'h0001_0000, 32'h0, 32'h0, 1'b0);
        add_particle(32'h0001_0000, 32'h1, 32'h0, 1'b0);
        add_particle(32'h0, 32'h0, 32'hfffe_0000, 1'b0);
        add_particle(32'h0, 32'h0003_0000, 32'h0, 1'b1);
        wait_drained();

        setup_sphere(32'h0, 32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 32'd31);
        add_particle(32'h7fff_ffff, 32'h0, 32'h0, 1'b0);
        add_particle(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
        wait_drained();
        write_reg(sbrf_pkg::CFG_FORCE_K, 32'h0);
        write_reg(sbrf_pkg::CFG_EXPONENT, 32'd1);
        add_particle(32'h0003_0000, 32'hfffd_0000, 32'h0, 1'b1);
        add_particle(32'h0002_0000, 32'h0, 32'h0, 1'b1);
        wait_drained();

        setup_sphere(32'h0, 32'h0, 32'h0, 32'h0002_0000, 32'h0001_0000, 32'd16);
        add_particle(32'h0003_8000, 32'h0, 32'h0, 1'b0);
        add_particle(32'h0, 32'h0010_0000, 32'h0, 1'b0);
        add_particle(32'h0, 32'h0, 32'h0002_0000, 1'b1);
        wait_drained();

        for (int p = 0; p < 8; p++)
            random_phase(200);

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
